FILE: design/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// Types and constants shared by the typed key hash unit: hash constants,
// type tags, datapath operations, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tkh_pkg;

  localparam logic [31:0] FNV_BASIS  = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [63:0] FMIX_M1    = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] FMIX_M2    = 64'hC4CE_B9FE_1A85_EC53;
  localparam logic [31:0] NIL_HASH   = 32'h9E37_79B9;
  localparam logic [31:0] TRUE_HASH  = 32'h85EB_CA6B;
  localparam logic [31:0] FALSE_HASH = 32'hC2B2_AE35;
  localparam int          FMIX_SHIFT = 33;
  localparam logic [10:0] EXP_BIAS   = 11'd1023;

  localparam logic [3:0] TYPE_NIL    = 4'd0;
  localparam logic [3:0] TYPE_BOOL   = 4'd1;
  localparam logic [3:0] TYPE_INT    = 4'd2;
  localparam logic [3:0] TYPE_FLOAT  = 4'd3;
  localparam logic [3:0] TYPE_STRING = 4'd4;

  typedef enum logic [3:0] {
    DP_HOLD,
    DP_LOAD,
    DP_NORM8,
    DP_NORM1,
    DP_ROUND,
    DP_XSHIFT,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_FOLD
  } dp_op_t;

  typedef enum logic [2:0] {
    KIND_CONST,
    KIND_STR_OPEN,
    KIND_STR_DONE,
    KIND_INT,
    KIND_MIX
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM8,
    S_NORM1,
    S_ROUND,
    S_XS1,
    S_M1A,
    S_M1B,
    S_M1C,
    S_XS2,
    S_M2A,
    S_M2B,
    S_M2C,
    S_XS3,
    S_FOLD,
    S_FIN
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_sel;   // 0: first finalizer constant, 1: second
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  top8_zero;
    logic  top_bit;
    logic  slot_free;
  } status_t;

endpackage

FILE: design/tkh_if.sv
// ----------------------------------------------------------------------------
// tkh_in_if / tkh_out_if
// Valid/ready channels of the typed key hash unit: key items in, hashes out.
// ----------------------------------------------------------------------------
interface tkh_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  value_type;
  logic [63:0] payload;
  logic [7:0]  text_byte;
  logic        byte_present;
  logic        last_byte;
  logic        null_ref;

  modport source (
    output valid, value_type, payload, text_byte, byte_present, last_byte, null_ref,
    input  ready
  );
  modport sink (
    input  valid, value_type, payload, text_byte, byte_present, last_byte, null_ref,
    output ready
  );
endinterface

interface tkh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_hash;

  modport source (output valid, key_hash, input ready);
  modport sink (input valid, key_hash, output ready);
endinterface

FILE: design/typed_key_hash_unit_top.sv
// Path: nil, bool and string-ending items go from acceptance straight to output;
//   floats, handles and zero ints run the finalizer; other ints normalize first.
// Throughput: one string byte without a result per cycle; any other item is taken
//   only when idle again; shared 32x32 multiplier, three passes per 64-bit product;
//   a full output register holds the finished hash in the controller, stalling intake.
// Reset (rst, synchronous): controller idle, output empty, FNV state at basis.
// ----------------------------------------------------------------------------
// typed_key_hash_unit_top
// Hashes one dynamically typed key to 32 bits: constants for nil and bool,
// FNV-1a over string bytes, a 64-bit finalizer for ints, floats and handles.
// ----------------------------------------------------------------------------
module typed_key_hash_unit_top (
  input  logic  clk,
  input  logic  rst,
  tkh_in_if.sink    in_ch,
  tkh_out_if.source out_ch
);
  import tkh_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: owns the input handshake and sequences every multi-cycle item.
  tkh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: string bytes fold on the accept edge; the output register here
  // lets the next item be taken and computed while a hash waits. A second
  // finished hash holds in the controller and stalls intake until the sink takes one.
  tkh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value_type   (in_ch.value_type),
    .payload      (in_ch.payload),
    .text_byte    (in_ch.text_byte),
    .byte_present (in_ch.byte_present),
    .last_byte    (in_ch.last_byte),
    .null_ref     (in_ch.null_ref),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .key_hash     (out_ch.key_hash)
  );

endmodule

FILE: design/tkh_ctrl.sv
// ----------------------------------------------------------------------------
// tkh_ctrl
// Controller: accepts items, steps the datapath through normalize, round
// and finalizer sequence, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tkh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tkh_pkg::status_t status,
  output tkh_pkg::cmd_t   cmd
);
  import tkh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.op       = DP_HOLD;
    cmd.mul_sel  = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LOAD;
          case (status.kind)
            KIND_CONST:    state_next = S_FIN;
            KIND_STR_DONE: state_next = S_FIN;
            KIND_STR_OPEN: state_next = S_IDLE;
            KIND_INT:      state_next = S_NORM8;
            KIND_MIX:      state_next = S_XS1;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_NORM8: begin
        if (status.top8_zero) begin
          cmd.op = DP_NORM8;
        end else begin
          state_next = S_NORM1;
        end
      end
      S_NORM1: begin
        if (!status.top_bit) begin
          cmd.op = DP_NORM1;
        end else begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.op     = DP_ROUND;
        state_next = S_XS1;
      end
      S_XS1: begin
        cmd.op     = DP_XSHIFT;
        state_next = S_M1A;
      end
      S_M1A: begin
        cmd.op     = DP_MUL0;
        state_next = S_M1B;
      end
      S_M1B: begin
        cmd.op     = DP_MUL1;
        state_next = S_M1C;
      end
      S_M1C: begin
        cmd.op     = DP_MUL2;
        state_next = S_XS2;
      end
      S_XS2: begin
        cmd.op     = DP_XSHIFT;
        state_next = S_M2A;
      end
      S_M2A: begin
        cmd.op      = DP_MUL0;
        cmd.mul_sel = 1'b1;
        state_next  = S_M2B;
      end
      S_M2B: begin
        cmd.op      = DP_MUL1;
        cmd.mul_sel = 1'b1;
        state_next  = S_M2C;
      end
      S_M2C: begin
        cmd.op      = DP_MUL2;
        cmd.mul_sel = 1'b1;
        state_next  = S_XS3;
      end
      S_XS3: begin
        cmd.op     = DP_XSHIFT;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.op     = DP_FOLD;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/tkh_dp.sv
// ----------------------------------------------------------------------------
// tkh_dp
// Datapath: FNV-1a accumulator, int to binary64 conversion, 64-bit finalizer
// on one shared 32x32 multiplier, and the output register.
// ----------------------------------------------------------------------------
module tkh_dp (
  input  logic             clk,
  input  logic             rst,
  input  tkh_pkg::cmd_t    cmd,
  output tkh_pkg::status_t status,
  input  logic [3:0]       value_type,
  input  logic [63:0]      payload,
  input  logic [7:0]       text_byte,
  input  logic             byte_present,
  input  logic             last_byte,
  input  logic             null_ref,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      key_hash
);
  import tkh_pkg::*;

  logic [31:0] fnv;
  logic [63:0] x;
  logic [63:0] acc;
  logic        sign_bit;
  logic [5:0]  msb;
  logic [31:0] res;

  logic [31:0] fnv_fold;
  logic [63:0] mag;
  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic        round_up;
  logic [53:0] q_round;
  logic [10:0] exp_field;
  kind_t       kind;

  assign fnv_fold = byte_present ? 32'((fnv ^ {24'd0, text_byte}) * FNV_PRIME) : fnv;
  assign mag      = payload[63] ? (64'd0 - payload) : payload;

  always_comb begin
    case (value_type)
      TYPE_NIL, TYPE_BOOL: kind = KIND_CONST;
      TYPE_STRING:         kind = (null_ref || last_byte) ? KIND_STR_DONE : KIND_STR_OPEN;
      TYPE_INT:            kind = (payload != 64'd0) ? KIND_INT : KIND_MIX;
      default:             kind = KIND_MIX;
    endcase
  end

  assign status.kind      = kind;
  assign status.top8_zero = (x[63:56] == 8'd0);
  assign status.top_bit   = x[63];
  assign status.slot_free = !out_valid || out_ready;

  // shared multiplier operands: low x low, low x high, high x low
  assign mul_c = cmd.mul_sel ? FMIX_M2 : FMIX_M1;
  always_comb begin
    case (cmd.op)
      DP_MUL1: begin
        mul_a = x[31:0];
        mul_b = mul_c[63:32];
      end
      DP_MUL2: begin
        mul_a = x[63:32];
        mul_b = mul_c[31:0];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // round to nearest even on the normalized magnitude
  assign round_up  = x[10] && ((x[9:0] != 10'd0) || x[11]);
  assign q_round   = {1'b0, x[63:11]} + {53'd0, round_up};
  assign exp_field = EXP_BIAS + {5'd0, msb} + {10'd0, q_round[53]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fnv       <= FNV_BASIS;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == DP_LOAD) begin
        if (value_type == TYPE_STRING && !null_ref && !last_byte) begin
          fnv <= fnv_fold;
        end else begin
          fnv <= FNV_BASIS;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      key_hash <= res;
    end
    case (cmd.op)
      DP_LOAD: begin
        sign_bit <= payload[63];
        msb      <= 6'd63;
        case (value_type)
          TYPE_NIL:    res <= NIL_HASH;
          TYPE_BOOL:   res <= (payload != 64'd0) ? TRUE_HASH : FALSE_HASH;
          TYPE_STRING: res <= null_ref ? 32'd0 : fnv_fold;
          TYPE_INT:    x   <= mag;
          TYPE_FLOAT:  x   <= (payload[62:0] == 63'd0) ? 64'd0 : payload;
          default:     x   <= payload ^ {28'd0, value_type, 32'd0};
        endcase
      end
      DP_NORM8: begin
        x   <= {x[55:0], 8'd0};
        msb <= msb - 6'd8;
      end
      DP_NORM1: begin
        x   <= {x[62:0], 1'b0};
        msb <= msb - 6'd1;
      end
      DP_ROUND: begin
        x <= {sign_bit, exp_field, q_round[51:0]};
      end
      DP_XSHIFT: begin
        x <= x ^ {33'd0, x[63:FMIX_SHIFT]};
      end
      DP_MUL0: begin
        acc <= prod;
      end
      DP_MUL1: begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
      DP_MUL2: begin
        x <= {acc[63:32] + prod[31:0], acc[31:0]};
      end
      DP_FOLD: begin
        res <= x[31:0] ^ x[63:32];
      end
      default: begin
      end
    endcase
  end

endmodule
